>>> hdl/sic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and widths for the sparse id compactor.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int KEY_W = 64;
    localparam int SEG_W = 32;
    localparam int VOC_W = 63;
    localparam int IDX_W = 12;
    localparam int POS_W = 16;

    typedef struct packed {
        logic             batch_start;
        logic             begins;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
    } front_item_t;

endpackage

>>> hdl/sic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_front
// Accepts beats, tracks segment and position, reduces the key (unless vocab is zero) by a
// bit-serial restoring remainder, and pushes classified items to the queue.
// ----------------------------------------------------------------------------
module sic_front #(
    parameter int MAX_ITEMS = 65536,
    parameter int CNT_W     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sic_pkg::VOC_W-1:0]    vocab,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_batch_start,
    input  logic [sic_pkg::SEG_W-1:0]    in_segment,
    input  logic [sic_pkg::KEY_W-1:0]    in_key,
    output logic                         push,
    output sic_pkg::front_item_t         push_item,
    input  logic                         push_ready
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    localparam logic [CNT_W-1:0] POS_MAX = CNT_W'(MAX_ITEMS - 1);

    fstate_t state_reg, state_next;
    logic [sic_pkg::SEG_W-1:0] seg_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic [sic_pkg::KEY_W-1:0] mag_reg;
    logic [sic_pkg::KEY_W:0]   rem_reg;
    logic [6:0]                bit_reg;
    logic                      neg_reg;
    sic_pkg::front_item_t      item_reg;

    logic [sic_pkg::KEY_W:0]   trial;
    logic [sic_pkg::KEY_W:0]   shifted;

    assign in_ready  = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH);
    assign push_item = item_reg;

    assign shifted = {rem_reg[sic_pkg::KEY_W-1:0], mag_reg[bit_reg[5:0]]};
    assign trial   = shifted - {2'b00, vocab};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_valid) state_next = (vocab == '0) ? F_PUSH : F_DIV;
            F_DIV:  if (bit_reg == 7'd0) state_next = F_PUSH;
            F_PUSH: if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            seg_reg   <= '1;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_IDLE && in_valid) begin
                logic [CNT_W-1:0] p;
                logic [sic_pkg::SEG_W-1:0] s;
                p = in_batch_start ? '0 : pos_reg;
                s = in_batch_start ? '1 : seg_reg;
                item_reg.batch_start <= in_batch_start;
                item_reg.begins      <= (in_segment != s);
                item_reg.pos         <= sic_pkg::POS_W'(p);
                item_reg.key         <= in_key;
                seg_reg <= in_segment;
                pos_reg <= (p < POS_MAX) ? p + 1'b1 : p;
                neg_reg <= in_key[sic_pkg::KEY_W-1];
                mag_reg <= in_key[sic_pkg::KEY_W-1] ? (~in_key + 1'b1) : in_key;
                rem_reg <= '0;
                bit_reg <= 7'd63;
            end else if (state_reg == F_DIV) begin
                logic [sic_pkg::KEY_W:0] r;
                r = trial[sic_pkg::KEY_W] ? shifted : trial;
                rem_reg <= r;
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == 7'd0)
                    item_reg.key <= neg_reg ? (~r[sic_pkg::KEY_W-1:0] + 1'b1)
                                            : r[sic_pkg::KEY_W-1:0];
            end
        end
    end
endmodule

>>> hdl/sic_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module sic_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  sic_pkg::front_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output sic_pkg::front_item_t rd_item
);
    sic_pkg::front_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

>>> hdl/sic_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_back
// Scans the key store one entry after another (read, compare), inserts unseen
// keys, holds the result in an output register, and takes one item at a time.
// ----------------------------------------------------------------------------
module sic_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int AW            = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  sic_pkg::front_item_t       q_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sic_pkg::IDX_W-1:0]  out_index,
    output logic                       out_new,
    output logic [sic_pkg::KEY_W-1:0]  out_key,
    output logic                       out_begins,
    output logic [sic_pkg::POS_W-1:0]  out_pos,
    output logic                       out_full
);
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_CMP  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    localparam logic [AW:0] DEPTH = (AW+1)'(TABLE_ENTRIES);

    bstate_t state_reg;
    logic [sic_pkg::KEY_W-1:0] store [TABLE_ENTRIES];
    logic [sic_pkg::KEY_W-1:0] rdata_reg;
    logic [AW:0]               count_reg;
    logic [AW:0]               scan_reg;
    sic_pkg::front_item_t      cur_reg;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;

    assign q_ready   = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);

    always_ff @(posedge aclk) begin
        if (wr_en) store[wr_addr] <= cur_reg.key;
        rdata_reg <= store[scan_reg[AW-1:0]];
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        if (state_reg == B_READ && scan_reg >= count_reg && count_reg < DEPTH)
            wr_en = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            count_reg <= '0;
        end else begin
            case (state_reg)
                B_IDLE: if (q_valid) begin
                    cur_reg   <= q_item;
                    scan_reg  <= '0;
                    if (q_item.batch_start) count_reg <= '0;
                    state_reg <= B_READ;
                end
                B_READ: begin
                    if (scan_reg >= count_reg) begin
                        out_key    <= cur_reg.key;
                        out_begins <= cur_reg.begins;
                        out_pos    <= cur_reg.pos;
                        if (count_reg < DEPTH) begin
                            out_index <= sic_pkg::IDX_W'(count_reg);
                            out_new   <= 1'b1;
                            out_full  <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            out_index <= '0;
                            out_new   <= 1'b0;
                            out_full  <= 1'b1;
                        end
                        state_reg <= B_OUT;
                    end else begin
                        state_reg <= B_CMP;
                    end
                end
                B_CMP: begin
                    if (rdata_reg == cur_reg.key) begin
                        out_key    <= cur_reg.key;
                        out_begins <= cur_reg.begins;
                        out_pos    <= cur_reg.pos;
                        out_index  <= sic_pkg::IDX_W'(scan_reg);
                        out_new    <= 1'b0;
                        out_full   <= 1'b0;
                        state_reg  <= B_OUT;
                    end else begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= B_READ;
                    end
                end
                B_OUT: if (out_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/sparse_id_compactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_id_compactor
// Dense renumbering of a batch's feature keys with segment-boundary flags.
// ----------------------------------------------------------------------------
// The front takes a beat and reduces its key by a 64-step serial remainder
// (skipped when vocabulary_size is zero), and takes no new beat until it has
// pushed the last one. The back scans the key store linearly, with a read
// state and a compare state per stored entry checked, and takes no new item
// until m_tready has taken its result. The two-entry queue lets both parts
// overlap, so the slower one sets the rate: the remainder while the table is
// small, the store scan once it holds more than about 31 keys. No clearing
// pass: entries above the fill count are never read.
module sparse_id_compactor #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MAX_ITEMS     = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [62:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // segment_number[31:0], feature_key[95:32]
    input  logic         s_tuser,   // batch_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // local_index[11:0], reduced_key[75:12],
                                    // item_position[91:76], zero pad
    output logic [2:0]   m_tuser    // is_new_key, segment_begins, table_full
);
    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ITEMS);

    logic [sic_pkg::VOC_W-1:0] vocab_reg;
    logic                 f_push, f_ready, q_valid, q_ready;
    sic_pkg::front_item_t f_item, q_item;
    logic [sic_pkg::IDX_W-1:0] o_index;
    logic [sic_pkg::KEY_W-1:0] o_key;
    logic [sic_pkg::POS_W-1:0] o_pos;
    logic o_new, o_begins, o_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) vocab_reg <= '0;
        else if (cfg_wr_en) vocab_reg <= cfg_wr_data;
    end

    sic_front #(.MAX_ITEMS(MAX_ITEMS), .CNT_W(CNT_W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .vocab(vocab_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_batch_start(s_tuser),
        .in_segment(s_tdata[31:0]), .in_key(s_tdata[95:32]),
        .push(f_push), .push_item(f_item), .push_ready(f_ready)
    );

    sic_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_push), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    sic_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .AW(AW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_index(o_index), .out_new(o_new), .out_key(o_key),
        .out_begins(o_begins), .out_pos(o_pos), .out_full(o_full)
    );

    assign m_tdata = {4'b0000, o_pos, o_key, o_index};
    assign m_tuser = {o_full, o_begins, o_new};
endmodule

>>> hdl/sic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_checker
// Port-level checks on the compactor, bound to the top level.
// ----------------------------------------------------------------------------
module sic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [2:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_newfull: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
        else $error("new and full together");
    a_fullidx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[11:0] == 12'd0)
        else $error("full beat with nonzero index");
endmodule

bind sparse_id_compactor sic_checker u_sic_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
